// ----- rtl/core/met_pkg.sv -----
// shared constants, register codes and types for the escape time block
package met_pkg;

    localparam int COORD_W    = 9;
    localparam int Q_W        = 32;
    localparam int FRAC_BITS  = 28;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int WIDTH_DEF  = 512;
    localparam int HEIGHT_DEF = 512;

    localparam logic [COUNT_W-1:0] LAST_ITER = 8'd255;

    localparam logic signed [Q_W-1:0] X_BEGIN_RST = -32'sd536870912;
    localparam logic signed [Q_W-1:0] X_END_RST   = 32'sd536870912;
    localparam logic signed [Q_W-1:0] Y_BEGIN_RST = -32'sd536870912;
    localparam logic signed [Q_W-1:0] Y_END_RST   = 32'sd536870912;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_BEGIN = 2'd0,
        REG_X_END   = 2'd1,
        REG_Y_BEGIN = 2'd2,
        REG_Y_END   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] count;
    } iter_status_t;

endpackage

// ----- rtl/core/met_map.sv -----
// pixel index to complex coordinate: multiply, reciprocal floor divide, saturate
module met_map #(
    parameter int DIV = met_pkg::WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [met_pkg::Q_W-1:0]     base,
    input  logic signed [met_pkg::Q_W-1:0]     limit,
    input  logic        [met_pkg::COORD_W-1:0] idx,
    output logic                               done,
    output logic signed [met_pkg::Q_W-1:0]     value
);
    import met_pkg::*;

    localparam int DIFF_W    = Q_W + 1;
    localparam int MW        = DIFF_W + COORD_W;
    localparam int PW        = MW + 1;
    localparam int SUM_W     = PW + 1;
    localparam int DW        = $clog2(DIV);
    localparam int HALF_W    = (PW + 1) / 2;
    localparam int REC_W     = PW + 1;
    localparam int ACC_W     = PW + REC_W;
    localparam int SH        = PW + DW;
    localparam int QUO_W     = ACC_W - SH;
    localparam int MAC_STEPS = 4;
    localparam int CNT_W     = $clog2(MAC_STEPS);

    // offset that makes the product non-negative, and the rounded-up reciprocal
    localparam logic [63:0] BIAS_K64 = ((64'd1 << (MW - 1)) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [63:0] BIAS64   = BIAS_K64 * 64'(DIV);
    localparam logic [63:0] REC64    = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);

    localparam logic [PW-1:0]     BIAS_K = BIAS_K64[PW-1:0];
    localparam logic [PW-1:0]     BIAS   = BIAS64[PW-1:0];
    localparam logic [REC_W-1:0]  REC    = REC64[REC_W-1:0];
    localparam logic [HALF_W-1:0] REC_LO = REC[HALF_W-1:0];
    localparam logic [HALF_W-1:0] REC_HI = REC[REC_W-1:HALF_W];

    localparam logic [CNT_W-1:0]        CNT_LAST = CNT_W'(MAC_STEPS - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI =
        $signed({{(SUM_W - Q_W + 1){1'b0}}, {(Q_W - 1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SAT_LO =
        $signed({{(SUM_W - Q_W + 1){1'b1}}, {(Q_W - 1){1'b0}}});

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_MUL  = 5'b00010,
        M_BIAS = 5'b00100,
        M_MAC  = 5'b01000,
        M_FIN  = 5'b10000
    } map_state_t;

    map_state_t               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     done_reg, done_next;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [COORD_W-1:0]       idx_reg;
    logic signed [PW-1:0]     prod_reg;
    logic [PW-1:0]            num_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic signed [Q_W-1:0]    value_reg;

    logic [HALF_W-1:0]        num_hi;
    logic [HALF_W-1:0]        mul_a, mul_b;
    logic [2*HALF_W-1:0]      mul_p;
    logic [ACC_W-1:0]         pp_ext;
    logic [ACC_W-1:0]         term;
    logic [QUO_W-1:0]         quo;
    logic [PW-1:0]            q_fin;
    logic signed [SUM_W-1:0]  sum;

    // one partial product of offset product times reciprocal per cycle
    assign num_hi = {{(2 * HALF_W - PW){1'b0}}, num_reg[PW-1:HALF_W]};
    assign mul_a  = cnt_reg[0] ? num_hi : num_reg[HALF_W-1:0];
    assign mul_b  = cnt_reg[1] ? REC_HI : REC_LO;
    assign mul_p  = mul_a * mul_b;
    assign pp_ext = {{(ACC_W - 2 * HALF_W){1'b0}}, mul_p};

    always_comb
    begin
        if (cnt_reg[0] && cnt_reg[1])
        begin
            term = pp_ext << (2 * HALF_W);
        end
        else if (cnt_reg[0] || cnt_reg[1])
        begin
            term = pp_ext << HALF_W;
        end
        else
        begin
            term = pp_ext;
        end
    end

    assign quo   = acc_reg[ACC_W-1:SH];
    assign q_fin = {{(PW - QUO_W){1'b0}}, quo} - BIAS_K;
    assign sum   = $signed({{(SUM_W - Q_W){base[Q_W-1]}}, base})
                 + $signed({q_fin[PW-1], q_fin});

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next = M_MUL;
                end
            end
            M_MUL:
            begin
                state_next = M_BIAS;
            end
            M_BIAS:
            begin
                cnt_next   = '0;
                state_next = M_MAC;
            end
            M_MAC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = M_FIN;
                end
            end
            M_FIN:
            begin
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE && start)
        begin
            diff_reg <= $signed({limit[Q_W-1], limit}) - $signed({base[Q_W-1], base});
            idx_reg  <= idx;
        end
        if (state_reg == M_MUL)
        begin
            prod_reg <= diff_reg * $signed({1'b0, idx_reg});
        end
        if (state_reg == M_BIAS)
        begin
            num_reg <= $unsigned(prod_reg) + BIAS;
            acc_reg <= '0;
        end
        if (state_reg == M_MAC)
        begin
            acc_reg <= acc_reg + term;
        end
        if (state_reg == M_FIN)
        begin
            if (sum > SAT_HI)
            begin
                value_reg <= Q_W'(SAT_HI);
            end
            else if (sum < SAT_LO)
            begin
                value_reg <= Q_W'(SAT_LO);
            end
            else
            begin
                value_reg <= sum[Q_W-1:0];
            end
        end
    end

    assign done  = done_reg;
    assign value = value_reg;

    a_map_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("map sequencer state not one-hot");

    a_map_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == M_IDLE)
        else $error("map finished but sequencer not idle");

    a_map_fin_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == M_FIN |-> $past(state_reg) == M_MAC && $past(cnt_reg) == CNT_LAST)
        else $error("map final phase out of order");

endmodule

// ----- rtl/core/met_iter.sv -----
// z = z*z + c iteration around one shared multiplier: each step goes SQR, SQI, PRD, then UPD if not yet escaped
module met_iter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic signed [met_pkg::Q_W-1:0] cr,
    input  logic signed [met_pkg::Q_W-1:0] ci,
    output met_pkg::iter_status_t          status
);
    import met_pkg::*;

    localparam int Z_W   = FRAC_BITS + 3;
    localparam int P_W   = 2 * Z_W;
    localparam int SQ_W  = 2 * FRAC_BITS + 4;
    localparam int SS_W  = SQ_W + 1;
    localparam int N_W   = Q_W + 2;

    localparam logic signed [N_W-1:0] TWO_N     = N_W'(2 ** (FRAC_BITS + 1));
    localparam logic signed [N_W-1:0] NEG_TWO_N = -TWO_N;
    localparam logic [SS_W-1:0]       FOUR_SQ   = SS_W'(1) << (2 * FRAC_BITS + 2);

    typedef enum logic [4:0] {
        I_IDLE = 5'b00001,
        I_SQR  = 5'b00010,
        I_SQI  = 5'b00100,
        I_PRD  = 5'b01000,
        I_UPD  = 5'b10000
    } iter_state_t;

    iter_state_t            state_reg, state_next;
    logic [COUNT_W-1:0]     iter_reg, iter_next;
    iter_status_t           status_reg, status_next;
    logic signed [Z_W-1:0]  zr_reg, zi_reg;
    logic signed [Q_W-1:0]  cr_reg, ci_reg;
    logic [SQ_W-1:0]        sr_reg, si_reg;
    logic signed [SQ_W-1:0] pr_reg;

    logic signed [Z_W-1:0]  mul_a, mul_b;
    logic signed [P_W-1:0]  mul_p;
    logic [SS_W-1:0]        sq_sum;
    logic signed [SQ_W-1:0] sq_diff, sq_sh, pr_sh;
    logic signed [N_W-1:0]  nr, ni;
    logic                   comp_out;

    always_comb
    begin
        case (state_reg)
            I_SQR:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            I_SQI:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign sq_sum   = {1'b0, sr_reg} + {1'b0, si_reg};
    assign sq_diff  = $signed(sr_reg) - $signed(si_reg);
    assign sq_sh    = sq_diff >>> FRAC_BITS;
    assign pr_sh    = pr_reg >>> (FRAC_BITS - 1);
    assign nr       = $signed(sq_sh[N_W-1:0]) + $signed({{(N_W - Q_W){cr_reg[Q_W-1]}}, cr_reg});
    assign ni       = $signed(pr_sh[N_W-1:0]) + $signed({{(N_W - Q_W){ci_reg[Q_W-1]}}, ci_reg});
    assign comp_out = (nr > TWO_N) || (nr < NEG_TWO_N) || (ni > TWO_N) || (ni < NEG_TWO_N);

    always_comb
    begin
        state_next        = state_reg;
        iter_next         = iter_reg;
        status_next.done  = 1'b0;
        status_next.count = status_reg.count;
        case (state_reg)
            I_IDLE:
            begin
                if (start)
                begin
                    iter_next  = '0;
                    state_next = I_SQR;
                end
            end
            I_SQR:
            begin
                state_next = I_SQI;
            end
            I_SQI:
            begin
                state_next = I_PRD;
            end
            I_PRD:
            begin
                // squares of the z left by the previous step
                if (sq_sum > FOUR_SQ)
                begin
                    status_next.done  = 1'b1;
                    status_next.count = iter_reg - 1'b1;
                    state_next        = I_IDLE;
                end
                else
                begin
                    state_next = I_UPD;
                end
            end
            I_UPD:
            begin
                if (comp_out || iter_reg == LAST_ITER)
                begin
                    status_next.done  = 1'b1;
                    status_next.count = iter_reg;
                    state_next        = I_IDLE;
                end
                else
                begin
                    iter_next  = iter_reg + 1'b1;
                    state_next = I_SQR;
                end
            end
            default:
            begin
                state_next = I_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= I_IDLE;
            iter_reg   <= '0;
            status_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            iter_reg   <= iter_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == I_IDLE && start)
        begin
            zr_reg <= '0;
            zi_reg <= '0;
            cr_reg <= cr;
            ci_reg <= ci;
        end
        if (state_reg == I_SQR)
        begin
            sr_reg <= mul_p[SQ_W-1:0];
        end
        if (state_reg == I_SQI)
        begin
            si_reg <= mul_p[SQ_W-1:0];
        end
        if (state_reg == I_PRD)
        begin
            pr_reg <= mul_p[SQ_W-1:0];
        end
        if (state_reg == I_UPD && !comp_out)
        begin
            zr_reg <= nr[Z_W-1:0];
            zi_reg <= ni[Z_W-1:0];
        end
    end

    assign status = status_reg;

    a_z_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == I_SQR |-> (N_W'(zr_reg) <= TWO_N) && (N_W'(zr_reg) >= NEG_TWO_N)
                            && (N_W'(zi_reg) <= TWO_N) && (N_W'(zi_reg) >= NEG_TWO_N))
        else $error("z component out of range at step start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg.done |-> state_reg == I_IDLE)
        else $error("iteration finished but sequencer not idle");

    a_upd_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == I_UPD |-> $past(state_reg) == I_PRD)
        else $error("update phase out of order");

endmodule

// ----- rtl/core/mandelbrot_escape_time_top.sv -----
// escape time top level: config registers, pixel capture, sequencing, result strobe
//
//  channel   signals                                   direction  handshake
//  config    cfg_valid cfg_ready cfg_index cfg_data    in         valid & ready
//  pixel     start busy column row                     in         start & !busy
//  result    done escape_count out_column out_row      out        done, one cycle
//
//  an item takes coordinate mapping (offset product, then a reciprocal
//  multiply in four partial products) plus iteration steps of SQR, SQI, PRD
//  and UPD on the shared multiplier, up to 256 steps: busy drops in the
//  cycle of the result strobe
//  reset clears control and loads the default window; no clearing pass
//  the result is shown for one cycle and a new item is taken in that cycle
module mandelbrot_escape_time_top #(
    parameter int WIDTH  = met_pkg::WIDTH_DEF,
    parameter int HEIGHT = met_pkg::HEIGHT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [met_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [met_pkg::Q_W-1:0]       cfg_data,
    input  logic                                 start,
    output logic                                 busy,
    input  logic        [met_pkg::COORD_W-1:0]   column,
    input  logic        [met_pkg::COORD_W-1:0]   row,
    output logic                                 done,
    output logic        [met_pkg::COUNT_W-1:0]   escape_count,
    output logic        [met_pkg::COORD_W-1:0]   out_column,
    output logic        [met_pkg::COORD_W-1:0]   out_row
);
    import met_pkg::*;

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_MAP  = 3'b010,
        T_ITER = 3'b100
    } top_state_t;

    top_state_t            state_reg, state_next;
    logic signed [Q_W-1:0] x_begin_reg, x_end_reg, y_begin_reg, y_end_reg;
    logic [COORD_W-1:0]    col_reg, row_reg;
    logic                  done_reg;
    logic [COUNT_W-1:0]    count_reg;

    logic                  accept;
    logic                  x_done, y_done;
    logic signed [Q_W-1:0] cr, ci;
    logic                  iter_start;
    iter_status_t          iter_status;

    assign accept     = start && state_reg == T_IDLE;
    assign iter_start = state_reg == T_MAP && x_done && y_done;

    met_map #(.DIV(WIDTH)) u_map_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .base  (x_begin_reg),
        .limit (x_end_reg),
        .idx   (column),
        .done  (x_done),
        .value (cr)
    );

    met_map #(.DIV(HEIGHT)) u_map_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .base  (y_end_reg),
        .limit (y_begin_reg),
        .idx   (row),
        .done  (y_done),
        .value (ci)
    );

    met_iter u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (iter_start),
        .cr     (cr),
        .ci     (ci),
        .status (iter_status)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    state_next = T_MAP;
                end
            end
            T_MAP:
            begin
                if (iter_start)
                begin
                    state_next = T_ITER;
                end
            end
            T_ITER:
            begin
                if (iter_status.done)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= T_IDLE;
            done_reg    <= 1'b0;
            x_begin_reg <= X_BEGIN_RST;
            x_end_reg   <= X_END_RST;
            y_begin_reg <= Y_BEGIN_RST;
            y_end_reg   <= Y_END_RST;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= state_reg == T_ITER && iter_status.done;
            if (cfg_valid)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_X_BEGIN: x_begin_reg <= $signed(cfg_data);
                    REG_X_END:   x_end_reg   <= $signed(cfg_data);
                    REG_Y_BEGIN: y_begin_reg <= $signed(cfg_data);
                    REG_Y_END:   y_end_reg   <= $signed(cfg_data);
                    default:     x_begin_reg <= x_begin_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg <= column;
            row_reg <= row;
        end
        if (iter_status.done)
        begin
            count_reg <= iter_status.count;
        end
    end

    assign cfg_ready    = 1'b1;
    assign busy         = state_reg != T_IDLE;
    assign done         = done_reg;
    assign escape_count = count_reg;
    assign out_column   = col_reg;
    assign out_row      = row_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("item accepted but block not busy");

    a_done_from_iter: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(iter_status.done) && !busy)
        else $error("result strobe without finished iteration");

    a_iter_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        iter_status.done |-> state_reg == T_ITER)
        else $error("iteration finished outside iterate state");

endmodule

// ----- test/testbench.sv -----
// testbench for the escape time block: directed and random pixels checked against a predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import met_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int DRAIN_CYCLES = 1200;
    localparam int RANDOM_PHASES = 6;
    localparam int PIXELS_PER_PHASE = 67;
    localparam int MAX_STEPS = 256;

    localparam logic signed [Q_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic signed [Q_W-1:0] Q_MAX = 32'h7fff_ffff;
    localparam logic signed [Q_W-1:0] Q_ZERO = 32'h0000_0000;
    localparam logic signed [Q_W-1:0] Q_QUARTER = 32'h0400_0000;
    localparam logic signed [Q_W-1:0] Q_CUSP_EDGE = 32'h0401_4000;
    localparam longint Q_TWO = longint'(1) <<< (FRAC_BITS + 1);
    localparam longint Q_FOUR_SQ = longint'(1) <<< (2 * FRAC_BITS + 2);
    localparam int MAP_SHIFT = $clog2(WIDTH_DEF);

    typedef struct packed {
        logic signed [Q_W-1:0] x_lo;
        logic signed [Q_W-1:0] x_hi;
        logic signed [Q_W-1:0] y_lo;
        logic signed [Q_W-1:0] y_hi;
        logic [COORD_W-1:0]    col;
        logic [COORD_W-1:0]    rw;
        int                    want;
    } pixel_case_t;

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] rw;
    } pixel_result_t;

    // want below zero means the predictor supplies the count
    pixel_case_t pixel_cases [25] = '{
        '{X_BEGIN_RST, X_END_RST, Y_BEGIN_RST, Y_END_RST, 9'd0, 9'd0, 0},
        '{X_BEGIN_RST, X_END_RST, Y_BEGIN_RST, Y_END_RST, 9'd511, 9'd511, 0},
        '{X_BEGIN_RST, X_END_RST, Y_BEGIN_RST, Y_END_RST, 9'd511, 9'd0, 0},
        '{X_BEGIN_RST, X_END_RST, Y_BEGIN_RST, Y_END_RST, 9'd0, 9'd511, 0},
        '{X_BEGIN_RST, X_END_RST, Y_BEGIN_RST, Y_END_RST, 9'd256, 9'd256, 255},
        '{X_BEGIN_RST, X_END_RST, Y_BEGIN_RST, Y_END_RST, 9'd128, 9'd256, 255},
        '{X_BEGIN_RST, X_END_RST, Y_BEGIN_RST, Y_END_RST, 9'd0, 9'd256, 255},
        '{X_BEGIN_RST, X_END_RST, Y_BEGIN_RST, Y_END_RST, 9'd256, 9'd0, 1},
        '{X_BEGIN_RST, X_END_RST, Y_BEGIN_RST, Y_END_RST, 9'd384, 9'd256, 2},
        '{X_BEGIN_RST, X_END_RST, Y_BEGIN_RST, Y_END_RST, 9'd320, 9'd256, -1},
        '{X_BEGIN_RST, X_END_RST, Y_BEGIN_RST, Y_END_RST, 9'd170, 9'd341, -1},
        '{X_BEGIN_RST, X_END_RST, Y_BEGIN_RST, Y_END_RST, 9'd341, 9'd170, -1},
        '{X_BEGIN_RST, X_END_RST, Y_BEGIN_RST, Y_END_RST, 9'd255, 9'd257, -1},
        '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 9'd511, 9'd511, 255},
        '{Q_MIN, Q_MAX, Q_MIN, Q_MAX, 9'd0, 9'd0, 0},
        '{Q_MIN, Q_MAX, Q_MIN, Q_MAX, 9'd511, 9'd511, 0},
        '{Q_MIN, Q_MAX, Q_MIN, Q_MAX, 9'd256, 9'd256, -1},
        '{Q_MAX, Q_MIN, Q_MAX, Q_MIN, 9'd0, 9'd0, 0},
        '{Q_MAX, Q_MIN, Q_MAX, Q_MIN, 9'd256, 9'd256, -1},
        // just right of the cusp: escape near the last step
        '{Q_QUARTER, Q_CUSP_EDGE, Q_ZERO, Q_ZERO, 9'd245, 9'd0, -1},
        '{Q_QUARTER, Q_CUSP_EDGE, Q_ZERO, Q_ZERO, 9'd250, 9'd0, -1},
        '{Q_QUARTER, Q_CUSP_EDGE, Q_ZERO, Q_ZERO, 9'd255, 9'd0, -1},
        '{Q_QUARTER, Q_CUSP_EDGE, Q_ZERO, Q_ZERO, 9'd260, 9'd0, -1},
        '{Q_QUARTER, Q_CUSP_EDGE, Q_ZERO, Q_ZERO, 9'd265, 9'd0, -1},
        '{Q_QUARTER, Q_CUSP_EDGE, Q_ZERO, Q_ZERO, 9'd270, 9'd0, -1}
    };

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [Q_W-1:0]        cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [COORD_W-1:0]    column = '0;
    logic [COORD_W-1:0]    row = '0;
    logic                  done;
    logic [COUNT_W-1:0]    escape_count;
    logic [COORD_W-1:0]    out_column;
    logic [COORD_W-1:0]    out_row;

    logic signed [Q_W-1:0] window_regs [4] = '{X_BEGIN_RST, X_END_RST, Y_BEGIN_RST, Y_END_RST};
    pixel_result_t         pending_pixels [$];
    pixel_result_t         oldest;
    int                    gap_pct = 0;
    int                    fail_count = 0;
    int                    cycle_count = 0;

    mandelbrot_escape_time_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .column       (column),
        .row          (row),
        .done         (done),
        .escape_count (escape_count),
        .out_column   (out_column),
        .out_row      (out_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint clamp_q(longint v);
        if (v > longint'(Q_MAX))
            return longint'(Q_MAX);
        if (v < longint'(Q_MIN))
            return longint'(Q_MIN);
        return v;
    endfunction

    function automatic logic [COUNT_W-1:0] predict_escape(logic [COORD_W-1:0] col,
                                                          logic [COORD_W-1:0] rw);
        longint cr;
        longint ci;
        longint zr;
        longint zi;
        longint nr;
        longint ni;
        longint xb;
        longint yt;
        xb = longint'(window_regs[REG_X_BEGIN]);
        yt = longint'(window_regs[REG_Y_END]);
        // image size is a power of two, so the floor divide is an arithmetic shift
        cr = clamp_q(xb + (((longint'(window_regs[REG_X_END]) - xb) * longint'(col))
                           >>> MAP_SHIFT));
        ci = clamp_q(yt + (((longint'(window_regs[REG_Y_BEGIN]) - yt) * longint'(rw))
                           >>> MAP_SHIFT));
        zr = 0;
        zi = 0;
        for (int i = 0; i < MAX_STEPS; i++)
        begin
            nr = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
            ni = ((2 * zr * zi) >>> FRAC_BITS) + ci;
            zr = nr;
            zi = ni;
            if (zr > Q_TWO || zr < -Q_TWO || zi > Q_TWO || zi < -Q_TWO ||
                zr * zr + zi * zi > Q_FOUR_SQ)
                return COUNT_W'(i);
        end
        return LAST_ITER;
    endfunction

    task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] rw,
                              input int want);
        logic          offer;
        pixel_result_t item;
        column <= col;
        row <= rw;
        do
        begin
            offer = ($urandom_range(99) >= gap_pct);
            start <= offer;
            @(posedge clk);
        end
        while (!(offer && !busy));
        item.count = (want < 0) ? predict_escape(col, rw) : COUNT_W'(want);
        item.col = col;
        item.rw = rw;
        pending_pixels.push_back(item);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_window(input logic signed [Q_W-1:0] xb, input logic signed [Q_W-1:0] xe,
                               input logic signed [Q_W-1:0] yb, input logic signed [Q_W-1:0] ye);
        logic signed [Q_W-1:0] vals [4];
        cfg_reg_t              idx;
        vals = '{xb, xe, yb, ye};
        wait_idle();
        for (int k = 0; k < 4; k++)
        begin
            idx = cfg_reg_t'(k);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= vals[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            window_regs[idx] = vals[k];
        end
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("result with no item pending: column %0d row %0d", out_column, out_row);
                fail_count++;
            end
            else
            begin
                oldest = pending_pixels.pop_front();
                if (escape_count !== oldest.count)
                begin
                    $error("escape_count: expected %0d, got %0d", oldest.count, escape_count);
                    fail_count++;
                end
                if (out_column !== oldest.col)
                begin
                    $error("out_column: expected %0d, got %0d", oldest.col, out_column);
                    fail_count++;
                end
                if (out_row !== oldest.rw)
                begin
                    $error("out_row: expected %0d, got %0d", oldest.rw, out_row);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    initial
    begin
        longint                cx;
        longint                cy;
        longint                half_x;
        longint                half_y;
        logic signed [Q_W-1:0] xb;
        logic signed [Q_W-1:0] xe;
        logic signed [Q_W-1:0] yb;
        logic signed [Q_W-1:0] ye;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 6;
        foreach (pixel_cases[n])
        begin
            if (pixel_cases[n].x_lo != window_regs[REG_X_BEGIN] ||
                pixel_cases[n].x_hi != window_regs[REG_X_END] ||
                pixel_cases[n].y_lo != window_regs[REG_Y_BEGIN] ||
                pixel_cases[n].y_hi != window_regs[REG_Y_END])
                load_window(pixel_cases[n].x_lo, pixel_cases[n].x_hi,
                            pixel_cases[n].y_lo, pixel_cases[n].y_hi);
            send_pixel(pixel_cases[n].col, pixel_cases[n].rw, pixel_cases[n].want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            gap_pct = (p < 2) ? 6 : (p < 4) ? 75 : 0;
            if (p == RANDOM_PHASES - 1)
            begin
                xb = $urandom;
                xe = $urandom;
                yb = $urandom;
                ye = $urandom;
            end
            else
            begin
                // windows of random size around the set, down to a few hundred lsb
                cx = -64'sd590558003 + longint'($urandom_range(751619276, 0));
                cy = -64'sd348966093 + longint'($urandom_range(697932186, 0));
                half_x = longint'(1) <<< $urandom_range(29, 8);
                half_y = longint'(1) <<< $urandom_range(29, 8);
                xb = Q_W'(cx - half_x);
                xe = Q_W'(cx + half_x);
                yb = Q_W'(cy - half_y);
                ye = Q_W'(cy + half_y);
            end
            if ($urandom_range(3) == 0)
                load_window(xe, xb, ye, yb);
            else
                load_window(xb, xe, yb, ye);
            repeat (PIXELS_PER_PHASE)
                send_pixel(COORD_W'($urandom_range(511)), COORD_W'($urandom_range(511)), -1);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
